FILE: design/clm_pkg.sv
// Shared types and constants for the circular linked list manager.
package clm_pkg;

  localparam int unsigned ID_W       = 4;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned ID_LIMIT   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_UNLINKED = 2'd2,
    ST_LINKED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_JOIN,
    S_UNLINK,
    S_DONE
  } state_e;

endpackage

FILE: design/clm_link_ram.sv
// Link store: one write port and one registered read port.
module clm_link_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/circular_linked_list_manager_unit.sv
// Circular doubly linked list manager: sequencer, head/tail registers, link stores.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser = opcode, tdata = node_id
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser = status, tdata = result fields
//
// A rejected operation goes from idle to the final step; an unlink passes the
// unlink step, an empty-list push the link step, other pushes the link and join
// steps, as each link store has one write port. The result sits in an output
// register, so the next beat is taken while it waits; the sequencer holds in its
// final step only while that register is still full. Reset clears marks, head, tail
// and output valid and sets the empty flag; link data is used only for linked nodes.
module circular_linked_list_manager_unit #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [clm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [3:0] node_id
  input  logic [clm_pkg::OP_W-1:0]         s_axis_tuser,  // [2:0] opcode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [clm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [3:0] removed_node,
                                                          // [7:4] front_node,
                                                          // [11:8] back_node,
                                                          // [12] list_is_empty
  output logic [clm_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  // Only node numbers that fit in node_id can ever be linked.
  localparam int unsigned POOL = (NODE_COUNT < clm_pkg::ID_LIMIT) ? NODE_COUNT
                                                                  : clm_pkg::ID_LIMIT;
  localparam int unsigned IW   = $clog2(POOL);

  clm_pkg::state_e  state_q, state_d;
  clm_pkg::status_e status_q, status_d;
  logic [clm_pkg::OP_W-1:0]       op_q, op_d;
  logic [IW-1:0]                  node_q, node_d;
  logic [clm_pkg::ID_W-1:0]       removed_q, removed_d;
  logic [IW-1:0]                  head_q, head_d;
  logic [IW-1:0]                  tail_q, tail_d;
  logic                           empty_q, empty_d;
  logic [POOL-1:0]                mark_q, mark_d;
  logic                           out_valid_q, out_valid_d;
  logic [clm_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [clm_pkg::STATUS_W-1:0]   out_user_q, out_user_d;

  logic          prev_we, next_we;
  logic [IW-1:0] prev_waddr, next_waddr;
  logic [IW-1:0] prev_wdata, next_wdata;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] prev_rdata, next_rdata;

  logic [clm_pkg::ID_W-1:0] in_id;
  logic [IW-1:0]            in_node;
  logic                     in_in_pool;
  logic                     in_linked;

  assign in_id      = s_axis_tdata[clm_pkg::ID_W-1:0];
  assign in_node    = in_id[IW-1:0];
  assign in_in_pool = ({1'b0, in_id} < (clm_pkg::ID_W+1)'(POOL));
  assign in_linked  = in_in_pool && mark_q[in_node];

  clm_link_ram #(.DEPTH(POOL), .WIDTH(IW)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

  clm_link_ram #(.DEPTH(POOL), .WIDTH(IW)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clm_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    node_q     <= node_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    node_d      = node_q;
    status_d    = status_q;
    removed_d   = removed_q;
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    mark_d      = mark_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    prev_we     = 1'b0;
    next_we     = 1'b0;
    prev_waddr  = node_q;
    next_waddr  = node_q;
    prev_wdata  = node_q;
    next_wdata  = node_q;
    rd_addr     = node_q;

    unique case (state_q)
      clm_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = s_axis_tuser;
          node_d    = in_node;
          status_d  = clm_pkg::ST_OK;
          removed_d = '0;
          state_d   = clm_pkg::S_DONE;
          unique case (s_axis_tuser)
            clm_pkg::OP_PUSH_FRONT, clm_pkg::OP_PUSH_BACK: begin
              if (!in_in_pool || in_linked) begin
                status_d = clm_pkg::ST_LINKED;
              end else begin
                state_d = clm_pkg::S_LINK;
              end
            end
            clm_pkg::OP_POP_FRONT, clm_pkg::OP_POP_BACK: begin
              if (empty_q) begin
                status_d = clm_pkg::ST_EMPTY;
              end else begin
                node_d  = (s_axis_tuser == clm_pkg::OP_POP_FRONT) ? head_q : tail_q;
                state_d = clm_pkg::S_UNLINK;
              end
            end
            clm_pkg::OP_REMOVE: begin
              if (!in_linked) begin
                status_d = clm_pkg::ST_UNLINKED;
              end else begin
                state_d = clm_pkg::S_UNLINK;
              end
            end
            default: ;
          endcase
          // fetch both links of the victim; data lands next cycle
          rd_addr = node_d;
        end
      end

      clm_pkg::S_LINK: begin
        prev_we         = 1'b1;
        next_we         = 1'b1;
        prev_wdata      = empty_q ? node_q : tail_q;
        next_wdata      = empty_q ? node_q : head_q;
        mark_d[node_q]  = 1'b1;
        if (empty_q) begin
          head_d  = node_q;
          tail_d  = node_q;
          empty_d = 1'b0;
          state_d = clm_pkg::S_DONE;
        end else begin
          state_d = clm_pkg::S_JOIN;
        end
      end

      clm_pkg::S_JOIN: begin
        // splice between old tail and head
        next_we    = 1'b1;
        next_waddr = tail_q;
        prev_we    = 1'b1;
        prev_waddr = head_q;
        if (op_q == clm_pkg::OP_PUSH_FRONT) begin
          head_d = node_q;
        end else begin
          tail_d = node_q;
        end
        state_d = clm_pkg::S_DONE;
      end

      clm_pkg::S_UNLINK: begin
        mark_d[node_q] = 1'b0;
        removed_d      = clm_pkg::ID_W'(node_q);
        if (next_rdata == node_q) begin
          empty_d = 1'b1;
          head_d  = '0;
          tail_d  = '0;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rdata;
          next_wdata = next_rdata;
          prev_we    = 1'b1;
          prev_waddr = next_rdata;
          prev_wdata = prev_rdata;
          if (head_q == node_q) begin
            head_d = next_rdata;
          end
          if (tail_q == node_q) begin
            tail_d = prev_rdata;
          end
        end
        state_d = clm_pkg::S_DONE;
      end

      clm_pkg::S_DONE: begin
        // hold until the output register frees up
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d  = status_q;
          out_data_d  = {3'b000,
                         empty_q,
                         empty_q ? {clm_pkg::ID_W{1'b0}} : clm_pkg::ID_W'(tail_q),
                         empty_q ? {clm_pkg::ID_W{1'b0}} : clm_pkg::ID_W'(head_q),
                         removed_q};
          state_d     = clm_pkg::S_IDLE;
        end
      end

      default: state_d = clm_pkg::S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == clm_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_empty_no_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (mark_q == '0))
    else $error("empty list still has linked nodes");

  a_head_linked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (mark_q[head_q] && mark_q[tail_q]))
    else $error("head or tail of a non-empty list is not linked");

  a_unlink_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clm_pkg::S_UNLINK) |-> ($past(state_q) == clm_pkg::S_IDLE))
    else $error("unlink step without a fresh link read");

  a_done_loads_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clm_pkg::S_DONE && (!out_valid_q || m_axis_tready)) |=>
      (out_valid_q && state_q == clm_pkg::S_IDLE))
    else $error("finished operation did not reach the output register");

endmodule

FILE: test/circular_linked_list_manager_unit_checker.sv
// Checker for the list manager: predicts each operation's result and compares result beats.
`timescale 1ns / 100ps
module circular_linked_list_manager_unit_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [clm_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [3:0] node_id
  input  logic [clm_pkg::OP_W-1:0]       s_axis_tuser,   // [2:0] opcode
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [clm_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] removed, [7:4] front,
                                                         // [11:8] back, [12] list_is_empty
  input  logic [clm_pkg::STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct packed {
    clm_pkg::status_e         status;
    logic [clm_pkg::ID_W-1:0] removed;
    logic [clm_pkg::ID_W-1:0] front;
    logic [clm_pkg::ID_W-1:0] back;
    logic                     none_linked;
  } list_view_t;

  logic [clm_pkg::ID_W-1:0]     prev_of [clm_pkg::ID_LIMIT];
  logic [clm_pkg::ID_W-1:0]     next_of [clm_pkg::ID_LIMIT];
  logic [clm_pkg::ID_LIMIT-1:0] on_list;
  logic [clm_pkg::ID_W-1:0]     head;
  logic                         list_empty;
  list_view_t                   pending_views_q[$];

  function automatic void unlink(input logic [clm_pkg::ID_W-1:0] n);
    logic [clm_pkg::ID_W-1:0] p;
    logic [clm_pkg::ID_W-1:0] q;
    p = prev_of[n];
    q = next_of[n];
    on_list[n] = 1'b0;
    if (q == n) begin
      list_empty = 1'b1;
      head = '0;
    end else begin
      next_of[p] = q;
      prev_of[q] = p;
      if (head == n) head = q;
    end
  endfunction

  // Apply one operation to the shadow list and return what the block should report.
  function automatic list_view_t apply_list_op(input logic [clm_pkg::OP_W-1:0] op,
                                               input logic [clm_pkg::ID_W-1:0] id);
    list_view_t               r;
    logic [clm_pkg::ID_W-1:0] tail;
    logic [clm_pkg::ID_W-1:0] victim;
    r = '0;
    r.status = clm_pkg::ST_OK;
    case (op)
      clm_pkg::OP_PUSH_FRONT, clm_pkg::OP_PUSH_BACK: begin
        if (on_list[id]) begin
          r.status = clm_pkg::ST_LINKED;
        end else begin
          if (list_empty) begin
            prev_of[id] = id;
            next_of[id] = id;
            head = id;
            list_empty = 1'b0;
          end else begin
            // splice in just before the head, i.e. at the back
            tail = prev_of[head];
            next_of[id] = head;
            prev_of[id] = tail;
            next_of[tail] = id;
            prev_of[head] = id;
          end
          on_list[id] = 1'b1;
          if (op == clm_pkg::OP_PUSH_FRONT) head = id;
        end
      end
      clm_pkg::OP_POP_FRONT, clm_pkg::OP_POP_BACK: begin
        if (list_empty) begin
          r.status = clm_pkg::ST_EMPTY;
        end else begin
          victim = (op == clm_pkg::OP_POP_FRONT) ? head : prev_of[head];
          unlink(victim);
          r.removed = victim;
        end
      end
      clm_pkg::OP_REMOVE: begin
        if (!on_list[id]) begin
          r.status = clm_pkg::ST_UNLINKED;
        end else begin
          unlink(id);
          r.removed = id;
        end
      end
      default: ;
    endcase
    r.none_linked = list_empty;
    if (!list_empty) begin
      r.front = head;
      r.back  = prev_of[head];
    end
    return r;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [clm_pkg::ID_W-1:0] want,
                                      input logic [clm_pkg::ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    list_view_t want;
    if (!rst_ni) begin
      on_list = '0;
      head = '0;
      list_empty = 1'b1;
      pending_views_q.delete();
      fail_count_o = 0;
    end else begin
      // compare first: a result never leaves in the cycle its operation arrives
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_views_q.size() == 0) begin
          $error("result beat with no operation waiting for it");
          fail_count_o++;
        end else begin
          want = pending_views_q[0];
          pending_views_q.delete(0);
          check_field("status", clm_pkg::ID_W'(want.status),
                      clm_pkg::ID_W'(m_axis_tuser));
          check_field("removed_node", want.removed, m_axis_tdata[3:0]);
          check_field("front_node", want.front, m_axis_tdata[7:4]);
          check_field("back_node", want.back, m_axis_tdata[11:8]);
          check_field("list_is_empty", clm_pkg::ID_W'(want.none_linked),
                      clm_pkg::ID_W'(m_axis_tdata[12]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_views_q = {pending_views_q,
                           apply_list_op(s_axis_tuser, s_axis_tdata[clm_pkg::ID_W-1:0])};
    end
    pending_o = pending_views_q.size();
  end

endmodule

FILE: test/circular_linked_list_manager_unit_tb.sv
// Testbench top for the list manager: reset, operation stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps
module circular_linked_list_manager_unit_tb;

  localparam logic [clm_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [clm_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int RANDOM_BEATS = 1350;
  localparam int PHASE_LEN    = 64;
  localparam int QUIET_FIRST  = 900;   // sender never idles for these beats
  localparam int QUIET_LAST   = 1100;
  localparam int HOLD_FIRST   = 1000;  // receiver cycles with ready held low
  localparam int HOLD_LAST    = 1300;
  localparam int RX_QUIET_FIRST = 2500;
  localparam int RX_QUIET_LAST  = 3700;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 3_000_000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [clm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [clm_pkg::OP_W-1:0]       s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [clm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [clm_pkg::STATUS_W-1:0]   m_axis_tuser;
  int                             fail_total;
  int                             views_pending;
  int                             rx_cyc = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  circular_linked_list_manager_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  circular_linked_list_manager_unit_checker list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_total),
    .pending_o    (views_pending)
  );

  // Result side: random stalls, one long hold-off to back the block up, one stall-free stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc >= HOLD_FIRST && rx_cyc < HOLD_LAST) begin
        m_axis_tready <= 1'b0;
      end else if (rx_cyc >= RX_QUIET_FIRST && rx_cyc < RX_QUIET_LAST) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 36);
      end
    end
  end

  // Offer one operation beat and hold it until accepted.
  task automatic send_beat(input logic [clm_pkg::OP_W-1:0] op,
                           input logic [clm_pkg::ID_W-1:0] id,
                           input logic no_idle);
    while (!no_idle && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(clm_pkg::IN_DATA_W-clm_pkg::ID_W){1'b0}}, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned                 roll;
    logic [clm_pkg::OP_W-1:0]    op;
    logic                        fill;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pops and remove on an empty list
    send_beat(clm_pkg::OP_POP_FRONT, 4'd0, 1'b0);
    send_beat(clm_pkg::OP_POP_BACK, 4'd15, 1'b0);
    send_beat(clm_pkg::OP_REMOVE, 4'd0, 1'b0);
    // two-node list: removing one leaves the other self-linked, then empty
    send_beat(clm_pkg::OP_PUSH_BACK, 4'd0, 1'b0);
    send_beat(clm_pkg::OP_PUSH_FRONT, 4'd15, 1'b0);
    send_beat(clm_pkg::OP_PUSH_BACK, 4'd15, 1'b0);
    send_beat(clm_pkg::OP_REMOVE, 4'd0, 1'b0);
    send_beat(clm_pkg::OP_REMOVE, 4'd15, 1'b0);
    send_beat(clm_pkg::OP_PUSH_FRONT, 4'd5, 1'b0);
    send_beat(clm_pkg::OP_PUSH_BACK, 4'd10, 1'b0);
    send_beat(clm_pkg::OP_PUSH_FRONT, 4'd5, 1'b0);
    send_beat(clm_pkg::OP_POP_BACK, 4'd0, 1'b0);
    send_beat(clm_pkg::OP_POP_FRONT, 4'd0, 1'b0);
    send_beat(OP_SPARE_FIRST, 4'd3, 1'b0);
    send_beat(OP_SPARE_LAST, 4'd12, 1'b0);
    // remove from middle, head and tail
    send_beat(clm_pkg::OP_PUSH_BACK, 4'd1, 1'b0);
    send_beat(clm_pkg::OP_PUSH_BACK, 4'd2, 1'b0);
    send_beat(clm_pkg::OP_PUSH_BACK, 4'd3, 1'b0);
    send_beat(clm_pkg::OP_PUSH_FRONT, 4'd4, 1'b0);
    send_beat(clm_pkg::OP_REMOVE, 4'd2, 1'b0);
    send_beat(clm_pkg::OP_REMOVE, 4'd4, 1'b0);
    send_beat(clm_pkg::OP_REMOVE, 4'd3, 1'b0);
    send_beat(OP_SPARE_FIRST + 3'd1, 4'd15, 1'b0);
    send_beat(clm_pkg::OP_POP_FRONT, 4'd0, 1'b0);

    // alternate phases that mostly fill the pool and phases that mostly drain it
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      fill = ((i / PHASE_LEN) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 5) begin
        op = clm_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end else if (roll < (fill ? 75 : 20)) begin
        op = $urandom_range(1) ? clm_pkg::OP_PUSH_FRONT : clm_pkg::OP_PUSH_BACK;
      end else if (roll < (fill ? 85 : 65)) begin
        op = $urandom_range(1) ? clm_pkg::OP_POP_FRONT : clm_pkg::OP_POP_BACK;
      end else begin
        op = clm_pkg::OP_REMOVE;
      end
      send_beat(op, clm_pkg::ID_W'($urandom_range(clm_pkg::ID_LIMIT - 1)),
                i >= QUIET_FIRST && i < QUIET_LAST);
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (views_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

endmodule
